### hw/rtl/dnsnd_pkg.sv
package dnsnd_pkg;

  // store and name bounds
  localparam int PACKET_BYTES   = 4096;
  localparam int MAX_NAME_BYTES = 256;
  localparam int ADDR_W         = $clog2(PACKET_BYTES);
  localparam int LIMIT_W        = ADDR_W + 1;
  // a 14-bit compression pointer may point anywhere, so the cursor spans it
  localparam int CURSOR_W       = (ADDR_W + 1 > 14) ? ADDR_W + 1 : 14;
  localparam int NAME_LEN_W     = $clog2(MAX_NAME_BYTES + 1);

  // input item actions
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  // wire-format byte classes
  localparam logic [7:0] LABEL_LIMIT  = 8'd64;
  localparam logic [7:0] POINTER_MARK = 8'd192;
  localparam logic [7:0] DOT_CHAR     = 8'h2E;

  // hop limit register
  localparam int          HOPS_W     = 5;
  localparam logic [4:0]  HOPS_RESET = 5'd8;

  // final status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNSUPPORTED = 3'd1,
    ST_OFFSET      = 3'd2,
    ST_HOPS        = 3'd3,
    ST_TOO_LONG    = 3'd4
  } status_code_t;

  // which byte a push appends
  typedef enum logic [1:0] {
    PUSH_DATA = 2'd0,
    PUSH_DOT  = 2'd1,
    PUSH_ZERO = 2'd2
  } push_sel_t;

  // controller to datapath
  typedef struct packed {
    logic         write;
    logic         start;
    logic         fetch;
    logic         push;
    push_sel_t    push_sel;
    logic         load_label;
    logic         dec_label;
    logic         add_walk;
    logic         hop_inc;
    logic         load_ptr_high;
    logic         take_ptr;
    logic         finish;
    status_code_t fin_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       cur_oob;
    logic [7:0] rd_byte;
    logic       label_last;
    logic       hop_full;
    logic       name_full;
    logic       fill_full;
    logic       out_free;
  } dp_stat_t;

endpackage

### hw/rtl/dnsnd_ram.sv
module dnsnd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/dnsnd_dp.sv
module dnsnd_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  dnsnd_pkg::dp_cmd_t          cmd,
  output dnsnd_pkg::dp_stat_t         stat,
  input  logic [11:0]                 address,
  input  logic [7:0]                  data_byte,
  input  logic [12:0]                 packet_length,
  input  logic                        cfg_valid,
  input  logic [4:0]                  cfg_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [63:0]                 name_bytes,
  output logic [3:0]                  byte_count,
  output logic                        last_chunk,
  output logic [2:0]                  status,
  output logic [11:0]                 consumed
);

  logic [dnsnd_pkg::HOPS_W-1:0]     max_hops;
  logic [dnsnd_pkg::CURSOR_W-1:0]   cursor;
  logic [dnsnd_pkg::LIMIT_W-1:0]    limit;
  logic [5:0]                       label_left;
  logic [dnsnd_pkg::HOPS_W-1:0]     hop_count;
  logic [5:0]                       ptr_high;
  logic                             pointer_seen;
  logic [12:0]                      walked;
  logic [11:0]                      consumed_count;
  logic [dnsnd_pkg::NAME_LEN_W-1:0] name_len;
  logic [63:0]                      buffer;
  logic [3:0]                       fill;
  logic [7:0]                       rd_byte;
  logic [7:0]                       push_byte;
  logic                             emit;
  logic                             out_free;
  logic [11:0]                      final_consumed;

  // packet store
  dnsnd_ram #(
    .WIDTH (8),
    .DEPTH (dnsnd_pkg::PACKET_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.write),
    .wr_addr (address[dnsnd_pkg::ADDR_W-1:0]),
    .wr_data (data_byte),
    .rd_en   (cmd.fetch),
    .rd_addr (cursor[dnsnd_pkg::ADDR_W-1:0]),
    .rd_data (rd_byte)
  );

  // status towards the controller
  assign out_free = !out_valid || !out_stall;
  always_comb begin
    stat.cur_oob    = cursor >= dnsnd_pkg::CURSOR_W'(limit);
    stat.rd_byte    = rd_byte;
    stat.label_last = label_left == 6'd1;
    stat.hop_full   = hop_count >= max_hops;
    stat.name_full  = name_len >= dnsnd_pkg::NAME_LEN_W'(dnsnd_pkg::MAX_NAME_BYTES);
    stat.fill_full  = fill[3];
    stat.out_free   = out_free;
  end

  // byte to append
  always_comb begin
    case (cmd.push_sel)
      dnsnd_pkg::PUSH_DATA: push_byte = rd_byte;
      dnsnd_pkg::PUSH_DOT:  push_byte = dnsnd_pkg::DOT_CHAR;
      default:              push_byte = 8'h00;
    endcase
  end

  // a push onto a full chunk sends that chunk first
  assign emit = cmd.push && fill[3];

  always_comb begin
    if (cmd.fin_status != dnsnd_pkg::ST_OK) begin
      final_consumed = 12'd0;
    end else if (pointer_seen) begin
      final_consumed = consumed_count;
    end else begin
      final_consumed = walked[11:0];
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_hops <= dnsnd_pkg::HOPS_RESET;
    end else if (cfg_valid) begin
      max_hops <= cfg_data;
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor         <= '0;
      limit          <= '0;
      label_left     <= '0;
      hop_count      <= '0;
      ptr_high       <= '0;
      pointer_seen   <= 1'b0;
      walked         <= '0;
      consumed_count <= '0;
      name_len       <= '0;
      buffer         <= '0;
      fill           <= '0;
    end else if (cmd.start) begin
      cursor         <= dnsnd_pkg::CURSOR_W'(address);
      limit          <= (packet_length > 13'(dnsnd_pkg::PACKET_BYTES))
                        ? dnsnd_pkg::LIMIT_W'(dnsnd_pkg::PACKET_BYTES)
                        : dnsnd_pkg::LIMIT_W'(packet_length);
      label_left     <= '0;
      hop_count      <= '0;
      ptr_high       <= '0;
      pointer_seen   <= 1'b0;
      walked         <= '0;
      consumed_count <= '0;
      name_len       <= '0;
      buffer         <= '0;
      fill           <= '0;
    end else begin
      if (cmd.fetch) begin
        cursor <= cursor + dnsnd_pkg::CURSOR_W'(1);
      end else if (cmd.take_ptr) begin
        cursor <= dnsnd_pkg::CURSOR_W'({ptr_high, rd_byte});
      end
      if (cmd.take_ptr && !pointer_seen) begin
        pointer_seen   <= 1'b1;
        consumed_count <= walked[11:0] + 12'd2;
      end
      if (cmd.add_walk && !pointer_seen) begin
        walked <= walked + 13'(rd_byte) + 13'd1;
      end
      if (cmd.load_label) begin
        label_left <= rd_byte[5:0];
      end else if (cmd.dec_label) begin
        label_left <= label_left - 6'd1;
      end
      if (cmd.hop_inc) begin
        hop_count <= hop_count + dnsnd_pkg::HOPS_W'(1);
      end
      if (cmd.load_ptr_high) begin
        ptr_high <= rd_byte[5:0];
      end
      // chunk assembly
      if (cmd.push) begin
        name_len <= name_len + dnsnd_pkg::NAME_LEN_W'(1);
        if (emit) begin
          buffer <= {56'd0, push_byte};
          fill   <= 4'd1;
        end else begin
          buffer <= buffer | ({56'd0, push_byte} << {fill[2:0], 3'b000});
          fill   <= fill + 4'd1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      name_bytes <= buffer;
      byte_count <= 4'd8;
      last_chunk <= 1'b0;
      status     <= dnsnd_pkg::ST_OK;
      consumed   <= 12'd0;
    end else if (cmd.finish) begin
      name_bytes <= buffer;
      byte_count <= fill;
      last_chunk <= 1'b1;
      status     <= cmd.fin_status;
      consumed   <= final_consumed;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (emit || cmd.finish) |-> out_free)
    else $error("output register overwritten while held");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> (fill != 4'd0) && (fill <= 4'd8))
    else $error("chunk fill out of range after push");

  a_name_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> name_len < dnsnd_pkg::NAME_LEN_W'(dnsnd_pkg::MAX_NAME_BYTES))
    else $error("push beyond name bound");
`endif

endmodule

### hw/rtl/dnsnd_ctrl.sv
module dnsnd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  dnsnd_pkg::dp_stat_t stat,
  output dnsnd_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_PROC,
    S_DOT,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_LABEL_START,
    PH_IN_LABEL,
    PH_POINTER_LOW
  } phase_t;

  state_t                  state, state_next;
  phase_t                  phase, phase_next;
  dnsnd_pkg::status_code_t end_status, end_status_next;
  logic                    push_wait;
  logic [7:0]              b;

  assign b        = stat.rd_byte;
  assign in_stall = state != S_IDLE;
  // a push that must send a full chunk waits for the output register
  assign push_wait = stat.fill_full && !stat.name_full && !stat.out_free;

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    end_status_next = end_status;
    cmd             = '0;
    cmd.fin_status  = end_status;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (action == dnsnd_pkg::ACT_DECODE) begin
            cmd.start       = 1'b1;
            phase_next      = PH_LABEL_START;
            end_status_next = dnsnd_pkg::ST_OK;
            state_next      = S_FETCH;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_FETCH: begin
        if (stat.cur_oob) begin
          end_status_next = dnsnd_pkg::ST_OFFSET;
          state_next      = S_FINISH;
        end else begin
          cmd.fetch  = 1'b1;
          state_next = S_PROC;
        end
      end
      S_PROC: begin
        unique case (phase)
          PH_LABEL_START: begin
            if (b < dnsnd_pkg::LABEL_LIMIT) begin
              if (b == 8'd0) begin
                // root label ends the name
                if (stat.name_full) begin
                  end_status_next = dnsnd_pkg::ST_TOO_LONG;
                  state_next      = S_FINISH;
                end else if (!push_wait) begin
                  cmd.push        = 1'b1;
                  cmd.push_sel    = dnsnd_pkg::PUSH_ZERO;
                  cmd.add_walk    = 1'b1;
                  end_status_next = dnsnd_pkg::ST_OK;
                  state_next      = S_FINISH;
                end
              end else begin
                cmd.add_walk   = 1'b1;
                cmd.load_label = 1'b1;
                phase_next     = PH_IN_LABEL;
                state_next     = S_FETCH;
              end
            end else if (b < dnsnd_pkg::POINTER_MARK) begin
              end_status_next = dnsnd_pkg::ST_UNSUPPORTED;
              state_next      = S_FINISH;
            end else if (stat.hop_full) begin
              end_status_next = dnsnd_pkg::ST_HOPS;
              state_next      = S_FINISH;
            end else begin
              cmd.hop_inc       = 1'b1;
              cmd.load_ptr_high = 1'b1;
              phase_next        = PH_POINTER_LOW;
              state_next        = S_FETCH;
            end
          end
          PH_IN_LABEL: begin
            if (stat.name_full) begin
              end_status_next = dnsnd_pkg::ST_TOO_LONG;
              state_next      = S_FINISH;
            end else if (!push_wait) begin
              cmd.push      = 1'b1;
              cmd.push_sel  = dnsnd_pkg::PUSH_DATA;
              cmd.dec_label = 1'b1;
              state_next    = stat.label_last ? S_DOT : S_FETCH;
            end
          end
          default: begin
            // low byte of a pointer
            cmd.take_ptr = 1'b1;
            phase_next   = PH_LABEL_START;
            state_next   = S_FETCH;
          end
        endcase
      end
      S_DOT: begin
        if (stat.name_full) begin
          end_status_next = dnsnd_pkg::ST_TOO_LONG;
          state_next      = S_FINISH;
        end else if (!push_wait) begin
          cmd.push     = 1'b1;
          cmd.push_sel = dnsnd_pkg::PUSH_DOT;
          phase_next   = PH_LABEL_START;
          state_next   = S_FETCH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_LABEL_START;
      end_status <= dnsnd_pkg::ST_OK;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      end_status <= end_status_next;
    end
  end

`ifndef SYNTHESIS
  a_start_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == S_FETCH)
    else $error("decode start did not lead to a fetch");

  a_fetch_proc: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |=> (state == S_PROC) && $stable(phase))
    else $error("fetched byte not processed next");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !in_stall)
    else $error("input still held after final item");
`endif

endmodule

### hw/rtl/dns_name_decompressor_top.sv
// Write items: accepted back to back.
// Decode items: after acceptance, each packet byte is read (registered read, then
//   decode), each label ends with a dot push, and a failed bounds check goes to the final item.
// A push onto a full chunk, and the final item, wait while the output register is held.
// Throughput: one decode at a time; the next item is taken once the final item is registered.
// Synchronous reset clears control state and sets the hop limit to 8, not the packet store.
module dns_name_decompressor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [11:0] address,
  input  logic [7:0]  data_byte,
  input  logic [12:0] packet_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] name_bytes,
  output logic [3:0]  byte_count,
  output logic        last_chunk,
  output logic [2:0]  status,
  output logic [11:0] consumed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  dnsnd_pkg::dp_cmd_t  cmd;
  dnsnd_pkg::dp_stat_t stat;

  // config register always writable
  assign cfg_ready = 1'b1;

  dnsnd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd)
  );

  dnsnd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .address       (address),
    .data_byte     (data_byte),
    .packet_length (packet_length),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .name_bytes    (name_bytes),
    .byte_count    (byte_count),
    .last_chunk    (last_chunk),
    .status        (status),
    .consumed      (consumed)
  );

endmodule

### tb/dns_name_decompressor_top_tb.sv
module dns_name_decompressor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // label type 10; type 01 is LABEL_LIMIT itself
  localparam logic [7:0] RSVD_LABEL    = 8'h80;
  localparam int         SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {
    AT_LENGTH,
    IN_LABEL,
    AT_POINTER_LOW
  } walk_phase_t;

  typedef struct packed {
    logic [63:0]             chars;
    logic [3:0]              count;
    logic                    is_last;
    dnsnd_pkg::status_code_t code;
    logic [11:0]             used;
  } chunk_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic        action        = dnsnd_pkg::ACT_LOAD;
  logic [11:0] address       = '0;
  logic [7:0]  data_byte     = '0;
  logic [12:0] packet_length = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [63:0] name_bytes;
  logic [3:0]  byte_count;
  logic        last_chunk;
  logic [2:0]  status;
  logic [11:0] consumed;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data      = '0;

  // shadow of the block's packet store and hop limit
  logic [7:0]  pkt_mem [dnsnd_pkg::PACKET_BYTES];
  bit          mem_written [dnsnd_pkg::PACKET_BYTES];
  logic [4:0]  hop_limit = dnsnd_pkg::HOPS_RESET;

  // scratch state of the name walk being predicted
  logic [63:0] walk_acc;
  int unsigned walk_fill;
  int unsigned walk_len;
  chunk_t      walk_chunks [$];

  chunk_t      name_chunks_due [$];
  int unsigned name_starts [$];

  int unsigned send_idle_pct  = 29;
  int unsigned recv_stall_pct = 83;
  int unsigned items_sent     = 0;
  int unsigned loads_sent     = 0;
  int unsigned decodes_sent   = 0;
  int unsigned chunks_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned ends_by_code [5];
  bit          decoded;

  dns_name_decompressor_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .address       (address),
    .data_byte     (data_byte),
    .packet_length (packet_length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .name_bytes    (name_bytes),
    .byte_count    (byte_count),
    .last_chunk    (last_chunk),
    .status        (status),
    .consumed      (consumed),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random back-pressure on the result side
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
  endtask

  // compare each accepted chunk with the oldest prediction
  always @(posedge clk) begin
    chunk_t want;
    if (!rst && out_valid && !out_stall) begin
      chunks_checked++;
      if (name_chunks_due.size() == 0) begin
        report_mismatch("unexpected chunk", name_bytes, 64'd0);
      end else begin
        want = name_chunks_due.pop_front();
        if (name_bytes !== want.chars)
          report_mismatch("name_bytes", name_bytes, want.chars);
        if (byte_count !== want.count)
          report_mismatch("byte_count", 64'(byte_count), 64'(want.count));
        if (last_chunk !== want.is_last)
          report_mismatch("last_chunk", 64'(last_chunk), 64'(want.is_last));
        if (status !== want.code)
          report_mismatch("status", 64'(status), 64'(want.code));
        if (consumed !== want.used)
          report_mismatch("consumed", 64'(consumed), 64'(want.used));
      end
    end
  end

  // add one output character; a full chunk leaves only when another byte follows
  function automatic bit append_char(input logic [7:0] c);
    if (walk_len >= dnsnd_pkg::MAX_NAME_BYTES) return 1'b0;
    if (walk_fill == 8) begin
      walk_chunks.push_back('{chars: walk_acc, count: 4'd8, is_last: 1'b0,
                              code: dnsnd_pkg::ST_OK, used: 12'd0});
      walk_acc  = '0;
      walk_fill = 0;
    end
    walk_acc[8*walk_fill +: 8] = c;
    walk_fill++;
    walk_len++;
    return 1'b1;
  endfunction

  // walk the wire name from start; clean drops to 0 if an unwritten byte would be read
  task automatic walk_wire_name(input int unsigned start, input int unsigned plen,
                                output bit clean);
    int unsigned             lim, cur, walked, hops, left, used;
    logic [5:0]              ptr_high;
    logic [7:0]              b;
    bit                      via_ptr, done;
    walk_phase_t             phase;
    dnsnd_pkg::status_code_t end_code;
    lim      = (plen > dnsnd_pkg::PACKET_BYTES) ? dnsnd_pkg::PACKET_BYTES : plen;
    cur      = start;
    walked   = 0;
    hops     = 0;
    left     = 0;
    used     = 0;
    ptr_high = '0;
    via_ptr  = 1'b0;
    done     = 1'b0;
    phase    = AT_LENGTH;
    end_code = dnsnd_pkg::ST_OK;
    clean    = 1'b1;
    walk_acc  = '0;
    walk_fill = 0;
    walk_len  = 0;
    walk_chunks.delete();
    while (!done) begin
      if (cur >= lim) begin
        end_code = dnsnd_pkg::ST_OFFSET;
        break;
      end
      if (!mem_written[cur]) begin
        clean = 1'b0;
        break;
      end
      b = pkt_mem[cur];
      cur++;
      case (phase)
        AT_LENGTH: begin
          if (b < dnsnd_pkg::LABEL_LIMIT) begin
            if (!via_ptr) walked += 32'(b) + 1;
            if (b == 8'd0) begin
              if (!append_char(8'd0)) begin
                end_code = dnsnd_pkg::ST_TOO_LONG;
                break;
              end
              done = 1'b1;
            end else begin
              left  = 32'(b);
              phase = IN_LABEL;
            end
          end else if (b < dnsnd_pkg::POINTER_MARK) begin
            end_code = dnsnd_pkg::ST_UNSUPPORTED;
            break;
          end else begin
            if (hops >= 32'(hop_limit)) begin
              end_code = dnsnd_pkg::ST_HOPS;
              break;
            end
            hops++;
            ptr_high = b[5:0];
            phase    = AT_POINTER_LOW;
          end
        end
        IN_LABEL: begin
          if (!append_char(b)) begin
            end_code = dnsnd_pkg::ST_TOO_LONG;
            break;
          end
          left--;
          if (left == 0) begin
            if (!append_char(dnsnd_pkg::DOT_CHAR)) begin
              end_code = dnsnd_pkg::ST_TOO_LONG;
              break;
            end
            phase = AT_LENGTH;
          end
        end
        default: begin
          cur = 32'({ptr_high, b});
          // only the first pointer fixes the consumed count
          if (!via_ptr) begin
            via_ptr = 1'b1;
            used    = walked + 2;
          end
          phase = AT_LENGTH;
        end
      endcase
    end
    if (end_code != dnsnd_pkg::ST_OK) used = 0;
    else if (!via_ptr) used = walked;
    walk_chunks.push_back('{chars: walk_acc, count: 4'(walk_fill), is_last: 1'b1,
                            code: end_code, used: 12'(used)});
  endtask

  // present one item after a random gap and hold it until accepted
  task automatic send_item(input logic act, input logic [11:0] addr,
                           input logic [7:0] dbyte, input logic [12:0] plen);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    address       <= addr;
    data_byte     <= dbyte;
    packet_length <= plen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_byte(input int unsigned addr, input logic [7:0] value);
    pkt_mem[addr]     = value;
    mem_written[addr] = 1'b1;
    loads_sent++;
    send_item(dnsnd_pkg::ACT_LOAD, 12'(addr), value, 13'($urandom_range(0, 8191)));
  endtask

  task automatic decode_name(input int unsigned start, input int unsigned plen,
                             output bit sent);
    bit clean;
    walk_wire_name(start, plen, clean);
    sent = clean;
    if (clean) begin
      foreach (walk_chunks[i]) name_chunks_due.push_back(walk_chunks[i]);
      ends_by_code[walk_chunks[$].code]++;
      decodes_sent++;
      send_item(dnsnd_pkg::ACT_DECODE, 12'(start), 8'($urandom_range(0, 255)), 13'(plen));
    end
  endtask

  task automatic lay_label(inout int unsigned at, input int unsigned len);
    put_byte(at, 8'(len));
    at++;
    repeat (len) begin
      put_byte(at, 8'($urandom_range(0, 255)));
      at++;
    end
  endtask

  task automatic lay_pointer(inout int unsigned at, input int unsigned target);
    logic [13:0] t;
    t = 14'(target);
    put_byte(at, dnsnd_pkg::POINTER_MARK | {2'b00, t[13:8]});
    put_byte(at + 1, t[7:0]);
    at += 2;
  endtask

  // stop sending, wait for every predicted chunk, then let the block go quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (name_chunks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_hop_limit(input logic [4:0] value);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    hop_limit = value;
  endtask

  // plain names: byte extremes in a label, and the root name at the top of the store
  task automatic test_plain_names();
    put_byte(0, 8'd2);
    put_byte(1, 8'h00);
    put_byte(2, 8'hFF);
    put_byte(3, 8'd0);
    decode_name(0, dnsnd_pkg::PACKET_BYTES, decoded);
    put_byte(dnsnd_pkg::PACKET_BYTES - 1, 8'd0);
    decode_name(dnsnd_pkg::PACKET_BYTES - 1, 8191, decoded);
  endtask

  // one pointer, and a pointer to a pointer
  task automatic test_pointers();
    int unsigned at;
    at = 4;
    lay_label(at, 1);
    lay_pointer(at, 0);
    lay_pointer(at, 4);
    decode_name(4, dnsnd_pkg::PACKET_BYTES, decoded);
    decode_name(8, dnsnd_pkg::PACKET_BYTES, decoded);
  endtask

  // label types 01 and 10 alone, and type 10 after a good label
  task automatic test_bad_labels();
    int unsigned at;
    put_byte(10, dnsnd_pkg::LABEL_LIMIT | 8'h3F);
    decode_name(10, dnsnd_pkg::PACKET_BYTES, decoded);
    put_byte(11, RSVD_LABEL);
    decode_name(11, dnsnd_pkg::PACKET_BYTES, decoded);
    at = 12;
    lay_label(at, 1);
    put_byte(at, 8'hBF);
    decode_name(12, dnsnd_pkg::PACKET_BYTES, decoded);
  endtask

  // reads outside the packet: empty packet, cut-off name, wild pointer, start at the packet end
  task automatic test_offset_errors();
    int unsigned at;
    decode_name(0, 0, decoded);
    decode_name(0, 2, decoded);
    at = 15;
    lay_pointer(at, 16383);
    decode_name(15, dnsnd_pkg::PACKET_BYTES, decoded);
    decode_name(dnsnd_pkg::PACKET_BYTES - 1, dnsnd_pkg::PACKET_BYTES - 1, decoded);
  endtask

  // hop limits of 1 and 16
  task automatic test_hop_limit();
    int unsigned at;
    set_hop_limit(5'd1);
    decode_name(8, dnsnd_pkg::PACKET_BYTES, decoded);
    decode_name(4, dnsnd_pkg::PACKET_BYTES, decoded);
    set_hop_limit(5'd16);
    at = 17;
    lay_label(at, 1);
    lay_pointer(at, 17);
    decode_name(17, dnsnd_pkg::PACKET_BYTES, decoded);
  endtask

  // a looping 15-byte label overruns the name bound with 16 hops allowed
  task automatic test_name_too_long();
    int unsigned at;
    set_hop_limit(5'd16);
    at = 21;
    lay_label(at, 15);
    lay_pointer(at, 21);
    decode_name(21, dnsnd_pkg::PACKET_BYTES, decoded);
  endtask

  // mostly well-formed names with random content, plus broken names and noise
  task automatic test_random_traffic(input int unsigned budget);
    int unsigned first, at, base, pick, len, tgt;
    first = items_sent;
    while (items_sent - first < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        base = $urandom_range(0, dnsnd_pkg::PACKET_BYTES - 200);
        at   = base;
        repeat ($urandom_range(1, 3)) begin
          len = ($urandom_range(0, 19) == 0) ? 63 : $urandom_range(1, 8);
          lay_label(at, len);
        end
        if (name_starts.size() != 0 && $urandom_range(0, 1)) begin
          lay_pointer(at, name_starts[$urandom_range(0, name_starts.size() - 1)]);
        end else begin
          put_byte(at, 8'd0);
          at++;
        end
        name_starts.push_back(base);
        if (name_starts.size() > 32) void'(name_starts.pop_front());
        decode_name(base, $urandom_range(at, 8191), decoded);
        if ($urandom_range(0, 2) == 0) decode_name(base, $urandom_range(0, at), decoded);
      end else if (pick < 75) begin
        // a label or two, then a bad type, a wild pointer or a loop back
        base = $urandom_range(0, dnsnd_pkg::PACKET_BYTES - 200);
        at   = base;
        repeat ($urandom_range(1, 2)) lay_label(at, $urandom_range(1, 6));
        case ($urandom_range(0, 3))
          0: put_byte(at, dnsnd_pkg::LABEL_LIMIT | 8'($urandom_range(0, 63)));
          1: put_byte(at, RSVD_LABEL | 8'($urandom_range(0, 63)));
          2: lay_pointer(at, $urandom_range(dnsnd_pkg::PACKET_BYTES, 16383));
          default: lay_pointer(at, base);
        endcase
        decode_name(base,
                    $urandom_range(0, 1) ? dnsnd_pkg::PACKET_BYTES : $urandom_range(0, 8191),
                    decoded);
      end else if (pick < 87) begin
        repeat ($urandom_range(1, 3))
          put_byte($urandom_range(0, dnsnd_pkg::PACKET_BYTES - 1),
                   8'($urandom_range(0, 255)));
      end else if (pick < 97) begin
        // arbitrary written offset; dropped if the walk would hit unwritten bytes
        tgt = $urandom_range(0, dnsnd_pkg::PACKET_BYTES - 1);
        if (mem_written[tgt]) decode_name(tgt, $urandom_range(0, 8191), decoded);
      end else begin
        settle_block();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_plain_names();
    test_pointers();
    test_bad_labels();
    test_offset_errors();
    test_hop_limit();
    test_name_too_long();

    set_hop_limit(5'd15);
    test_random_traffic(115);

    send_idle_pct  = 83;
    recv_stall_pct = 29;
    set_hop_limit(5'($urandom_range(1, 16)));
    test_random_traffic(115);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_hop_limit(5'd8);
    test_random_traffic(115);

    settle_block();
    $display("Run covered %0d byte loads and %0d decodes, %0d chunks checked, hop limits 1 to 16.",
             loads_sent, decodes_sent, chunks_checked);
    $display("Decode endings: ok %0d, bad label %0d, outside packet %0d, hops %0d, too long %0d",
             ends_by_code[dnsnd_pkg::ST_OK], ends_by_code[dnsnd_pkg::ST_UNSUPPORTED],
             ends_by_code[dnsnd_pkg::ST_OFFSET], ends_by_code[dnsnd_pkg::ST_HOPS],
             ends_by_code[dnsnd_pkg::ST_TOO_LONG]);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Timeout: block stopped responding, %0d chunks still due", name_chunks_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
